@@ rtl/core/msic_pkg.sv @@
// ----------------------------------------------------------------------------
// msic_pkg
// Shared widths and the command type that travels from the front end to the
// sort engine through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package msic_pkg;

    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 11;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_last;
        logic               keep;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/core/msic_front.sv @@
// ----------------------------------------------------------------------------
// msic_front
// Input front end. Accepts beats, decides whether each value fits in the
// store of the current set, and pushes the classified command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msic_front #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [msic_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_is_last,
    output logic                                o_ready,
    input  logic                                i_full,
    output logic                                o_push,
    output msic_pkg::t_cmd                      o_cmd
);
    import msic_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          keep;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign keep    = r_cnt < CW'(MAX_ITEMS);

    always_comb begin
        o_cmd.value   = $unsigned(i_value);
        o_cmd.is_last = i_is_last;
        o_cmd.keep    = keep;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_is_last) begin
                n_cnt = '0;
            end else if (keep) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/msic_queue.sv @@
// ----------------------------------------------------------------------------
// msic_queue
// Two-entry command queue between the front end and the sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

module msic_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msic_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output msic_pkg::t_cmd o_cmd
);
    import msic_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_slot[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/msic_back.sv @@
// ----------------------------------------------------------------------------
// msic_back
// Sort engine. Loads values into store A, runs bottom-up merge passes that
// alternate between stores A and B while counting inversions, then streams
// the sorted set through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msic_back #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  msic_pkg::t_cmd                      i_q_cmd,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [msic_pkg::VALUE_W-1:0] o_sorted_value,
    output logic        [msic_pkg::TOTAL_W-1:0] o_inversion_count,
    output logic                                o_last_out
);
    import msic_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = CW + 2;
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SETUP,
        S_MERGE,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [IW-1:0]       r_w, n_w;
    logic [IW-1:0]       r_lo, n_lo;
    logic [IW-1:0]       r_mid, n_mid;
    logic [IW-1:0]       r_hi, n_hi;
    logic [IW-1:0]       r_i, n_i;
    logic [IW-1:0]       r_j, n_j;
    logic [IW-1:0]       r_k, n_k;
    logic                r_par, n_par;
    logic                r_ov, n_ov;
    logic [VALUE_W-1:0]  r_oval, n_oval;
    logic [TOTAL_W-1:0]  r_otot, n_otot;
    logic                r_olast, n_olast;

    logic [VALUE_W-1:0]  mem_a [MAX_ITEMS];
    logic [VALUE_W-1:0]  mem_b [MAX_ITEMS];
    logic [VALUE_W-1:0]  r_a_l, r_a_r, r_b_l, r_b_r;
    logic                we_a, we_b;
    logic [AW-1:0]       wa;
    logic [VALUE_W-1:0]  wd;

    logic [IW-1:0]       n_ext;
    logic [IW-1:0]       sum_m, sum_h;
    logic [VALUE_W-1:0]  head_l, head_r;
    logic                left_ok, right_ok, take_r;
    logic [CW-1:0]       cnt_after;

    assign n_ext    = IW'(r_cnt);
    assign sum_m    = r_lo + r_w;
    assign sum_h    = r_lo + (r_w << 1);
    assign head_l   = r_par ? r_b_l : r_a_l;
    assign head_r   = r_par ? r_b_r : r_a_r;
    assign left_ok  = r_i < r_mid;
    assign right_ok = r_j < r_hi;
    assign take_r   = !left_ok || (right_ok && ($signed(head_l) > $signed(head_r)));
    assign cnt_after = r_cnt + CW'(i_q_cmd.keep);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_total = r_total;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_par   = r_par;
        n_ov    = r_ov && !i_ready;
        n_oval  = r_oval;
        n_otot  = r_otot;
        n_olast = r_olast;
        o_q_pop = 1'b0;
        we_a    = 1'b0;
        we_b    = 1'b0;
        wa      = r_k[AW-1:0];
        wd      = head_l;
        unique case (r_state)
            S_LOAD: begin
                o_q_pop = 1'b1;
                wa      = r_cnt[AW-1:0];
                wd      = i_q_cmd.value;
                if (i_q_valid) begin
                    we_a  = i_q_cmd.keep;
                    n_cnt = cnt_after;
                    if (i_q_cmd.is_last) begin
                        n_total = '0;
                        n_w     = IW'(1);
                        n_lo    = '0;
                        n_par   = 1'b0;
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                priority if (r_w >= n_ext) begin
                    n_i     = '0;
                    n_state = S_OUT;
                end else if (r_lo >= n_ext) begin
                    n_w   = r_w << 1;
                    n_lo  = '0;
                    n_par = !r_par;
                end else begin
                    n_mid   = (sum_m > n_ext) ? n_ext : sum_m;
                    n_hi    = (sum_h > n_ext) ? n_ext : sum_h;
                    n_i     = r_lo;
                    n_j     = (sum_m > n_ext) ? n_ext : sum_m;
                    n_k     = r_lo;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                wd   = take_r ? head_r : head_l;
                we_a = r_par;
                we_b = !r_par;
                if (take_r) begin
                    n_j = r_j + 1'b1;
                    if (left_ok) begin
                        n_total = r_total + TOTAL_W'(r_mid - r_i);
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
                n_k = r_k + 1'b1;
                if ((r_k + 1'b1) == r_hi) begin
                    n_lo    = sum_h;
                    n_state = S_SETUP;
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_oval  = head_l;
                    n_otot  = r_total;
                    n_olast = (r_i + 1'b1) == n_ext;
                    n_i     = r_i + 1'b1;
                    if ((r_i + 1'b1) == n_ext) begin
                        n_cnt   = '0;
                        n_total = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa] <= wd;
        end
        r_a_l <= mem_a[n_i[AW-1:0]];
        r_a_r <= mem_a[n_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[wa] <= wd;
        end
        r_b_l <= mem_b[n_i[AW-1:0]];
        r_b_r <= mem_b[n_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_total <= '0;
            r_w     <= '0;
            r_lo    <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_par   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_w     <= n_w;
            r_lo    <= n_lo;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_par   <= n_par;
            r_ov    <= n_ov;
        end
        r_oval  <= n_oval;
        r_otot  <= n_otot;
        r_olast <= n_olast;
    end

    assign o_valid           = r_ov;
    assign o_sorted_value    = $signed(r_oval);
    assign o_inversion_count = r_otot;
    assign o_last_out        = r_olast;

endmodule

`default_nettype wire

@@ rtl/core/merge_sort_inversion_count.sv @@
// ----------------------------------------------------------------------------
// merge_sort_inversion_count
// Collects a set of signed values, sorts it with bottom-up merge passes and
// returns the sorted values, each tagged with the set's inversion count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Beat contents
//  input     in         i_valid / o_ready    i_value, i_is_last
//  output    out        o_valid / i_ready    o_sorted_value, o_inversion_count,
//                                            o_last_out
//
// Loading pops a beat whenever the queue holds one. Sorting n values takes
// ceil(log2 n) merge passes, each merging adjacent runs from one store into
// the other, after a setup step per run. Results then leave at one per cycle
// while i_ready is high. Reset is synchronous and clears control state only;
// the stores are not cleared. The two-entry queue takes beats during a sort
// and drops o_ready when full.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_inversion_count #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [msic_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_is_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [msic_pkg::VALUE_W-1:0] o_sorted_value,
    output logic        [msic_pkg::TOTAL_W-1:0] o_inversion_count,
    output logic                                o_last_out
);
    import msic_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    msic_front #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_value  (i_value),
        .i_is_last(i_is_last),
        .o_ready  (o_ready),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    msic_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_cmd  (q_cmd)
    );

    msic_back #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sorted_value   (o_sorted_value),
        .o_inversion_count(o_inversion_count),
        .o_last_out       (o_last_out)
    );

endmodule

`default_nettype wire

@@ rtl/core/msic_check.sv @@
// ----------------------------------------------------------------------------
// msic_check
// Port-level checks: output beats hold under stall, each set leaves in
// ascending order with one inversion count, and that count stays in range.
// ----------------------------------------------------------------------------
`default_nettype none

module msic_check #(
    parameter int MAX_ITEMS = 64
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [msic_pkg::VALUE_W-1:0] o_sorted_value,
    input logic        [msic_pkg::TOTAL_W-1:0] o_inversion_count,
    input logic                                o_last_out
);
    import msic_pkg::*;

    localparam int MAX_TOTAL = MAX_ITEMS * (MAX_ITEMS - 1) / 2;

    logic                      r_in_set;
    logic signed [VALUE_W-1:0] r_prev;
    logic        [TOTAL_W-1:0] r_prev_cnt;
    logic                      out_beat;

    assign out_beat = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_set <= 1'b0;
        end else if (out_beat) begin
            r_in_set <= !o_last_out;
        end
        if (out_beat) begin
            r_prev     <= o_sorted_value;
            r_prev_cnt <= o_inversion_count;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sorted_value)
            && $stable(o_inversion_count) && $stable(o_last_out))
        else $error("Output beat changed while stalled.");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_in_set |-> o_sorted_value >= r_prev)
        else $error("Sorted values are not ascending within a set.");

    a_count_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_in_set |-> o_inversion_count == r_prev_cnt)
        else $error("Inversion count changed within a set.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_inversion_count <= TOTAL_W'(MAX_TOTAL))
        else $error("Inversion count exceeds the pair count of a full set.");

endmodule

bind merge_sort_inversion_count msic_check #(
    .MAX_ITEMS(MAX_ITEMS)
) u_msic_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_sorted_value   (o_sorted_value),
    .o_inversion_count(o_inversion_count),
    .o_last_out       (o_last_out)
);

`default_nettype wire
